// ----- rtl/lsr_pkg.sv -----
// Shared types and constants for the piecewise-linear table with ratchet.
// Used by lsr_ctrl, lsr_dp and linear_spline_with_ratchet; no dependencies.
`timescale 1ns / 1ps

package lsr_pkg;

  // Table depth, data width (Q8.8) and fraction width of the interpolation weight.
  localparam int POINTS = 8;
  localparam int DATA_W = 16;
  localparam int FRAC_W = 16;
  localparam int IDX_W  = $clog2(POINTS);
  localparam int NPTS_W = 4;
  localparam int CNT_W  = $clog2(FRAC_W);

  // Input item layout: tdata width rounded up to whole bytes.
  localparam int IN_BITS   = 4 * DATA_W + IDX_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int CMD_W     = 2;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_NUM_POINTS = 1'b0;
  localparam logic REG_RATCHET_EN = 1'b1;

  // Item commands carried in tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_EVAL   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_PRESET = 2'd2
  } item_cmd_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_SCAN,
    S_SETUP,
    S_DIV,
    S_MUL,
    S_SUM,
    S_OUT
  } state_t;

  // Table read pointer operations.
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_ONE,
    PTR_LAST,
    PTR_INC
  } ptr_op_t;

  // Result register sources.
  typedef enum logic [1:0] {
    RES_HOLD,
    RES_RD_LEVEL,
    RES_PREV_LEVEL,
    RES_SUM
  } res_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_eval;
    logic    wr_entry;
    logic    preset;
    ptr_op_t ptr_op;
    logic    cap_prev;
    logic    cap_bracket;
    logic    setup;
    logic    div_step;
    logic    mul;
    res_op_t res_op;
    logic    emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic few_points;
    logic x_le_rd;
    logic x_ge_rd;
    logic span_bad;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/linear_spline_with_ratchet.sv -----
// Top level of the piecewise-linear interpolation table with ratchet.
// Depends on lsr_pkg, lsr_ctrl, lsr_dp (and lsr_ram through lsr_dp).
`timescale 1ns / 1ps

// Evaluates y(x) by linear interpolation over a table of up to 8 Q8.8 knots,
// clamping to the end levels outside the table, with an optional ratchet that
// outputs the running maximum. One item is handled at a time. Table writes,
// ratchet presets and unused commands are taken without leaving the idle
// state. An evaluation checks both ends first, then scans the knots through
// the single read port of the table RAM, and a bit-serial restoring divider
// forms the weight. A reversed or empty span, or x on the left knot, ends
// with the left level. With fewer than two points in use the result is 0.
// A finished result waits in the output register, and the block takes the
// next item while it waits. Configuration: register 0 (address 0x0) is
// num_points, register 1 (address 0x4) is ratchet_enable; write them only
// while the block is idle.
module linear_spline_with_ratchet (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] x, [18:16] entry_index, [34:19] knot_position,
  // [50:35] knot_level, [66:51] preset_level, [71:67] zero
  input  logic [lsr_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] cmd
  input  logic [lsr_pkg::CMD_W-1:0]        in_tuser,
  // Result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] y
  output logic [lsr_pkg::DATA_W-1:0]       out_tdata,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lsr_pkg::APB_AW-1:0]       paddr,
  input  logic [lsr_pkg::APB_DW-1:0]       pwdata,
  output logic [lsr_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);

  localparam int DW = lsr_pkg::DATA_W;
  localparam int IW = lsr_pkg::IDX_W;

  lsr_pkg::ctrl_cmd_t                ctrl_cmd;
  lsr_pkg::dp_stat_t                 dp_stat;
  logic [lsr_pkg::NPTS_W-1:0]        num_points_r;
  logic                              ratchet_en_r;
  logic                              cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= lsr_pkg::NPTS_W'(2);
      ratchet_en_r <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == lsr_pkg::REG_NUM_POINTS) begin
        num_points_r <= pwdata[lsr_pkg::NPTS_W-1:0];
      end else begin
        ratchet_en_r <= pwdata[0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    if (paddr[2] == lsr_pkg::REG_RATCHET_EN) begin
      prdata = {{(lsr_pkg::APB_DW-1){1'b0}}, ratchet_en_r};
    end else begin
      prdata = {{(lsr_pkg::APB_DW-lsr_pkg::NPTS_W){1'b0}}, num_points_r};
    end
  end

  lsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .stat      (dp_stat),
    .cmd       (ctrl_cmd)
  );

  lsr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (ctrl_cmd),
    .stat             (dp_stat),
    .in_x             (in_tdata[DW-1:0]),
    .in_entry_index   (in_tdata[DW+IW-1:DW]),
    .in_knot_position (in_tdata[2*DW+IW-1:DW+IW]),
    .in_knot_level    (in_tdata[3*DW+IW-1:2*DW+IW]),
    .in_preset_level  (in_tdata[4*DW+IW-1:3*DW+IW]),
    .num_points       (num_points_r),
    .ratchet_en       (ratchet_en_r),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata)
  );

endmodule

// ----- rtl/lsr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/lsr_ctrl.sv -----
// Sequencing controller: steps one item through end checks, knot scan,
// division, multiply and output. Depends on lsr_pkg.
`timescale 1ns / 1ps

module lsr_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [lsr_pkg::CMD_W-1:0]  in_cmd,
  input  lsr_pkg::dp_stat_t          stat,
  output lsr_pkg::ctrl_cmd_t         cmd
);

  lsr_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt       = state_r;
    in_tready       = 1'b0;
    cmd             = '0;
    cmd.ptr_op      = lsr_pkg::PTR_HOLD;
    cmd.res_op      = lsr_pkg::RES_HOLD;

    case (state_r)
      lsr_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_cmd)
            lsr_pkg::CMD_EVAL: begin
              cmd.load_eval = 1'b1;
              if (stat.few_points) begin
                state_nxt = lsr_pkg::S_OUT;
              end else begin
                cmd.ptr_op = lsr_pkg::PTR_ZERO;
                state_nxt  = lsr_pkg::S_RD_FIRST;
              end
            end
            lsr_pkg::CMD_WRITE: begin
              cmd.wr_entry = 1'b1;
            end
            lsr_pkg::CMD_PRESET: begin
              cmd.preset = 1'b1;
            end
            default: begin
              // Unused command: the item is dropped.
            end
          endcase
        end
      end

      // First entry is being read; queue the last entry behind it.
      lsr_pkg::S_RD_FIRST: begin
        cmd.ptr_op = lsr_pkg::PTR_LAST;
        state_nxt  = lsr_pkg::S_CHK_FIRST;
      end

      // Clamp at or below the first knot.
      lsr_pkg::S_CHK_FIRST: begin
        cmd.cap_prev = 1'b1;
        if (stat.x_le_rd) begin
          cmd.res_op = lsr_pkg::RES_RD_LEVEL;
          state_nxt  = lsr_pkg::S_OUT;
        end else begin
          cmd.ptr_op = lsr_pkg::PTR_ONE;
          state_nxt  = lsr_pkg::S_CHK_LAST;
        end
      end

      // Clamp at or above the last knot.
      lsr_pkg::S_CHK_LAST: begin
        if (stat.x_ge_rd) begin
          cmd.res_op = lsr_pkg::RES_RD_LEVEL;
          state_nxt  = lsr_pkg::S_OUT;
        end else begin
          cmd.ptr_op = lsr_pkg::PTR_INC;
          state_nxt  = lsr_pkg::S_SCAN;
        end
      end

      // Walk the knots until one lies above x; the last one always does.
      lsr_pkg::S_SCAN: begin
        if (!stat.x_ge_rd) begin
          cmd.cap_bracket = 1'b1;
          state_nxt       = lsr_pkg::S_SETUP;
        end else begin
          cmd.cap_prev = 1'b1;
          cmd.ptr_op   = lsr_pkg::PTR_INC;
        end
      end

      // Degenerate span takes the left level; otherwise start the divider.
      lsr_pkg::S_SETUP: begin
        if (stat.span_bad) begin
          cmd.res_op = lsr_pkg::RES_PREV_LEVEL;
          state_nxt  = lsr_pkg::S_OUT;
        end else begin
          cmd.setup = 1'b1;
          state_nxt = lsr_pkg::S_DIV;
        end
      end

      lsr_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = lsr_pkg::S_MUL;
        end
      end

      lsr_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = lsr_pkg::S_SUM;
      end

      lsr_pkg::S_SUM: begin
        cmd.res_op = lsr_pkg::RES_SUM;
        state_nxt  = lsr_pkg::S_OUT;
      end

      // Hand the result to the output register once it is free.
      lsr_pkg::S_OUT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = lsr_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lsr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lsr_dp.sv -----
// Datapath: knot table RAM, scan registers, restoring divider, multiplier,
// ratchet and output register. Depends on lsr_pkg and lsr_ram.
`timescale 1ns / 1ps

module lsr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lsr_pkg::ctrl_cmd_t                  cmd,
  output lsr_pkg::dp_stat_t                   stat,
  input  logic signed [lsr_pkg::DATA_W-1:0]   in_x,
  input  logic        [lsr_pkg::IDX_W-1:0]    in_entry_index,
  input  logic signed [lsr_pkg::DATA_W-1:0]   in_knot_position,
  input  logic signed [lsr_pkg::DATA_W-1:0]   in_knot_level,
  input  logic signed [lsr_pkg::DATA_W-1:0]   in_preset_level,
  input  logic        [lsr_pkg::NPTS_W-1:0]   num_points,
  input  logic                                ratchet_en,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic        [lsr_pkg::DATA_W-1:0]   out_tdata
);

  localparam int DW = lsr_pkg::DATA_W;
  localparam int FW = lsr_pkg::FRAC_W;
  localparam int PW = DW + FW + 2;

  logic        [2*DW-1:0]           rd_data;
  logic signed [DW-1:0]             rd_knot;
  logic signed [DW-1:0]             rd_level;
  logic        [lsr_pkg::NPTS_W-1:0] n_eff;
  logic        [lsr_pkg::IDX_W-1:0] last_idx;

  logic        [lsr_pkg::IDX_W-1:0] ptr_r, ptr_nxt;
  logic signed [DW-1:0]             x_r;
  logic signed [DW-1:0]             prev_k_r, prev_l_r;
  logic signed [DW-1:0]             k1_r, l1_r;
  logic        [DW:0]               rem_r;
  logic        [DW:0]               den_r;
  logic        [FW-1:0]             q_r;
  logic        [lsr_pkg::CNT_W-1:0] cnt_r;
  logic signed [DW:0]               diff_r;
  logic signed [PW-1:0]             prod_r;
  logic signed [DW-1:0]             res_r, res_nxt;
  logic                             skip_r;
  logic signed [DW-1:0]             ratch_r;
  logic                             out_valid_r;
  logic        [DW-1:0]             out_data_r;

  logic signed [DW:0]               span_d;
  logic        [DW:0]               num_w;
  logic        [DW+1:0]             rem_sh;
  logic        [DW+2:0]             trial;
  logic                             q_bit;
  logic signed [DW-1:0]             y_val;

  // Knot table: position in the low half, level in the high half.
  lsr_ram #(
    .WIDTH (2 * DW),
    .DEPTH (lsr_pkg::POINTS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.wr_entry),
    .waddr (in_entry_index),
    .wdata ({in_knot_level, in_knot_position}),
    .raddr (ptr_r),
    .rdata (rd_data)
  );

  assign rd_knot  = rd_data[DW-1:0];
  assign rd_level = rd_data[2*DW-1:DW];

  // Points in use, saturated to the table depth.
  assign n_eff = (num_points > lsr_pkg::NPTS_W'(lsr_pkg::POINTS)) ?
                 lsr_pkg::NPTS_W'(lsr_pkg::POINTS) : num_points;
  assign last_idx = lsr_pkg::IDX_W'(n_eff - lsr_pkg::NPTS_W'(1));

  // Read pointer for the table.
  always_comb begin
    case (cmd.ptr_op)
      lsr_pkg::PTR_ZERO: ptr_nxt = '0;
      lsr_pkg::PTR_ONE:  ptr_nxt = lsr_pkg::IDX_W'(1);
      lsr_pkg::PTR_LAST: ptr_nxt = last_idx;
      lsr_pkg::PTR_INC:  ptr_nxt = ptr_r + lsr_pkg::IDX_W'(1);
      default:           ptr_nxt = ptr_r;
    endcase
  end

  // Span width and divider numerator.
  assign span_d = {k1_r[DW-1], k1_r} - {prev_k_r[DW-1], prev_k_r};
  assign num_w  = {x_r[DW-1], x_r} - {prev_k_r[DW-1], prev_k_r};

  // One restoring division step; the remainder stays below the span.
  assign rem_sh = {rem_r, 1'b0};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_r};
  assign q_bit  = ~trial[DW+2];

  // Result source selection; a new evaluation starts from a zero result.
  always_comb begin
    case (cmd.res_op)
      lsr_pkg::RES_RD_LEVEL:   res_nxt = rd_level;
      lsr_pkg::RES_PREV_LEVEL: res_nxt = prev_l_r;
      lsr_pkg::RES_SUM:        res_nxt = prev_l_r + prod_r[DW+FW-1:FW];
      default:                 res_nxt = res_r;
    endcase
    if (cmd.load_eval) begin
      res_nxt = '0;
    end
  end

  // Ratchet keeps the highest result when enabled.
  always_comb begin
    if (ratchet_en && !skip_r && (ratch_r > res_r)) begin
      y_val = ratch_r;
    end else begin
      y_val = res_r;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    res_r <= res_nxt;
    if (cmd.load_eval) begin
      x_r    <= in_x;
      skip_r <= stat.few_points;
    end
    if (cmd.cap_prev) begin
      prev_k_r <= rd_knot;
      prev_l_r <= rd_level;
    end
    if (cmd.cap_bracket) begin
      k1_r <= rd_knot;
      l1_r <= rd_level;
    end
    if (cmd.setup) begin
      rem_r  <= num_w;
      den_r  <= span_d;
      cnt_r  <= lsr_pkg::CNT_W'(FW - 1);
      diff_r <= {l1_r[DW-1], l1_r} - {prev_l_r[DW-1], prev_l_r};
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? trial[DW:0] : rem_sh[DW:0];
      q_r   <= {q_r[FW-2:0], q_bit};
      cnt_r <= cnt_r - lsr_pkg::CNT_W'(1);
    end
    if (cmd.mul) begin
      prod_r <= $signed({1'b0, q_r}) * diff_r;
    end
  end

  // Ratchet level and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratch_r     <= {1'b1, {(DW-1){1'b0}}};
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.preset) begin
        ratch_r <= in_preset_level;
      end else if (cmd.emit && ratchet_en && !skip_r) begin
        ratch_r <= y_val;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= y_val;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status to the controller.
  assign stat.few_points = (num_points < lsr_pkg::NPTS_W'(2));
  assign stat.x_le_rd    = (x_r <= rd_knot);
  assign stat.x_ge_rd    = (x_r >= rd_knot);
  assign stat.span_bad   = span_d[DW] || (span_d == '0) || (x_r <= prev_k_r);
  assign stat.div_done   = (cnt_r == '0);
  assign stat.out_free   = !out_valid_r || out_tready;

endmodule
